@@ design/packet_reassembly_crc_check_macros.svh @@
// Assertion macros used by the checker file.
`ifndef PACKET_REASSEMBLY_CRC_CHECK_MACROS_SVH
`define PACKET_REASSEMBLY_CRC_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ design/prc_pkg.sv @@
package prc_pkg;

  // Request codes on req_type
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_COLLECT = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [1:0] ST_MISMATCH   = 2'd2;
  localparam logic [1:0] ST_SHORT      = 2'd3;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_COLLECT,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  slot;
    logic [4:0]  total;
    logic [7:0]  data;
    logic        first;
  } cmd_t;

  // One byte of reflected CRC-32
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/prc_front.sv @@
module prc_front import prc_pkg::*; (
  input  logic       start,
  input  logic [1:0] req_type,
  input  logic [3:0] packet_index,
  input  logic [4:0] total_packets,
  input  logic [7:0] data_byte,
  input  logic       first_of_packet,
  input  logic       q_full,
  output logic       busy,
  output logic       push,
  output cmd_t       push_cmd
);

  logic accept;

  assign busy   = q_full;
  assign accept = start && !busy;

  always_comb begin
    push_cmd.slot  = packet_index;
    push_cmd.total = total_packets;
    push_cmd.data  = data_byte;
    push_cmd.first = first_of_packet;
    push_cmd.op    = CMD_WRITE;
    push           = 1'b0;
    unique case (req_type)
      REQ_BYTE: begin
        push_cmd.op = CMD_WRITE;
        push        = accept;
      end
      REQ_COLLECT: begin
        push_cmd.op = CMD_COLLECT;
        push        = accept;
      end
      REQ_CLEAR: begin
        push_cmd.op = CMD_CLEAR;
        push        = accept;
      end
      // drop the unused request code
      default: push = 1'b0;
    endcase
  end

endmodule

@@ design/prc_queue.sv @@
module prc_queue import prc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

@@ design/prc_back.sv @@
module prc_back import prc_pkg::*; #(
  parameter int MAX_PACKETS  = 16,
  parameter int PACKET_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        done,
  output logic [1:0]  status,
  output logic [12:0] payload_bytes,
  output logic [31:0] computed_crc
);

  localparam int SLOT_W      = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int SLOTC_W     = $clog2(MAX_PACKETS + 1);
  localparam int LEN_W       = $clog2(PACKET_BYTES + 1);
  localparam int STORE_DEPTH = MAX_PACKETS * PACKET_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int TOT_W       = $clog2(STORE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t               state;
  logic [7:0]           store [STORE_DEPTH];
  logic [LEN_W-1:0]     slot_length [MAX_PACKETS];
  logic [MAX_PACKETS-1:0] occupied;
  logic [SLOTC_W-1:0]   occ_count;
  logic [TOT_W-1:0]     total_len;
  logic [4:0]           expected_count;

  logic [SLOTC_W-1:0]   cur_slot;
  logic [LEN_W-1:0]     cur_off;
  logic [TOT_W-1:0]     byte_pos;
  logic [TOT_W-1:0]     body_len;
  logic [31:0]          crc_acc;
  logic [31:0]          rx_crc;
  logic [7:0]           rd_data;
  logic                 rd_valid;

  logic [SLOT_W-1:0]    slot_sel;
  logic [LEN_W-1:0]     sel_len;
  logic                 sel_occ;
  logic [LEN_W-1:0]     off_sel;
  logic [ADDR_W-1:0]    byte_addr;
  logic                 wr_in_range;
  logic [LEN_W-1:0]     wr_base;
  logic                 wr_room;
  logic [LEN_W-1:0]     wr_len_next;
  logic                 do_write;
  logic                 walk_in;
  logic                 walk_take;
  logic                 mem_we;
  logic [31:0]          crc_upd;
  logic [31:0]          crc_final;
  logic                 crc_match;

  always_comb begin
    slot_sel    = (state == S_IDLE) ? SLOT_W'(q_cmd.slot) : SLOT_W'(cur_slot);
    sel_len     = slot_length[slot_sel];
    sel_occ     = occupied[slot_sel];
    wr_in_range = (32'(q_cmd.slot) < MAX_PACKETS);
    wr_base     = q_cmd.first ? '0 : sel_len;
    wr_room     = (32'(wr_base) < PACKET_BYTES);
    wr_len_next = wr_room ? (wr_base + LEN_W'(1)) : wr_base;
    off_sel     = (state == S_IDLE) ? wr_base : cur_off;
    byte_addr   = ADDR_W'(32'(slot_sel) * PACKET_BYTES + 32'(off_sel));
    q_pop       = (state == S_IDLE) && !q_empty;
    do_write    = q_pop && (q_cmd.op == CMD_WRITE) && wr_in_range;
    mem_we      = do_write && wr_room;
    walk_in     = (32'(cur_slot) < MAX_PACKETS);
    walk_take   = (state == S_WALK) && walk_in && sel_occ && (cur_off < sel_len);
    crc_upd     = crc32_byte(crc_acc, rd_data);
    crc_final   = ~crc_acc;
    crc_match   = (rx_crc == crc_final);
  end

  // Byte store: one write port for packet bytes, one registered read for the walk
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[byte_addr] <= q_cmd.data;
    end
    if (walk_take) begin
      rd_data <= store[byte_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      done           <= 1'b0;
      rd_valid       <= 1'b0;
      occupied       <= '0;
      slot_length    <= '{default: '0};
      occ_count      <= '0;
      total_len      <= '0;
      expected_count <= '0;
    end else begin
      done     <= 1'b0;
      rd_valid <= walk_take;
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_cmd.op)
              CMD_WRITE: begin
                expected_count <= q_cmd.total;
                if (wr_in_range) begin
                  occupied[slot_sel]    <= 1'b1;
                  slot_length[slot_sel] <= wr_len_next;
                  total_len <= total_len - TOT_W'(sel_len) + TOT_W'(wr_len_next);
                  if (!sel_occ) begin
                    occ_count <= occ_count + SLOTC_W'(1);
                  end
                end
              end
              CMD_CLEAR: begin
                occupied    <= '0;
                slot_length <= '{default: '0};
                occ_count   <= '0;
                total_len   <= '0;
              end
              CMD_COLLECT: begin
                if (32'(occ_count) != 32'(expected_count)) begin
                  done          <= 1'b1;
                  status        <= ST_INCOMPLETE;
                  payload_bytes <= '0;
                  computed_crc  <= '0;
                end else if (total_len < TOT_W'(4)) begin
                  done          <= 1'b1;
                  status        <= ST_SHORT;
                  payload_bytes <= '0;
                  computed_crc  <= '0;
                end else begin
                  state    <= S_WALK;
                  cur_slot <= '0;
                  cur_off  <= '0;
                  byte_pos <= '0;
                  crc_acc  <= CRC_INIT;
                  body_len <= total_len - TOT_W'(4);
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          // consume the byte read last cycle: body into the CRC, trailer into rx_crc
          if (rd_valid) begin
            if (byte_pos < body_len) begin
              crc_acc <= crc_upd;
            end else begin
              rx_crc <= {rd_data, rx_crc[31:8]};
            end
            byte_pos <= byte_pos + TOT_W'(1);
          end
          if (walk_take) begin
            cur_off <= cur_off + LEN_W'(1);
          end else if (walk_in) begin
            cur_slot <= cur_slot + SLOTC_W'(1);
            cur_off  <= '0;
          end else if (!rd_valid) begin
            done          <= 1'b1;
            status        <= crc_match ? ST_OK : ST_MISMATCH;
            payload_bytes <= crc_match ? 13'(body_len) : '0;
            computed_crc  <= crc_final;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/packet_reassembly_crc_check.sv @@
// Channel   | Ports                                              | Transfer
// ----------+----------------------------------------------------+--------------------------
// request   | start, busy, req_type, packet_index,               | start && !busy at clk edge
//           | total_packets, data_byte, first_of_packet          |
// result    | done, status, payload_bytes, computed_crc          | done high for one cycle
//
// Packet byte and clear transactions sustain one per cycle while the queue is not full.
// A collect that passes the count and length checks walks every slot and byte through the
// single read port of the byte store; up to four transactions queue behind it, then busy.
// rst is synchronous, active high; it empties all slots and the queue.
// The receiver cannot stall; the result ports hold each result until the next one.
module packet_reassembly_crc_check import prc_pkg::*; #(
  parameter int MAX_PACKETS  = 16,
  parameter int PACKET_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  packet_index,
  input  logic [4:0]  total_packets,
  input  logic [7:0]  data_byte,
  input  logic        first_of_packet,
  output logic        done,
  output logic [1:0]  status,
  output logic [12:0] payload_bytes,
  output logic [31:0] computed_crc
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cmd_t q_cmd;

  // Front: take request transactions and classify them into commands
  prc_front u_front (
    .start           (start),
    .req_type        (req_type),
    .packet_index    (packet_index),
    .total_packets   (total_packets),
    .data_byte       (data_byte),
    .first_of_packet (first_of_packet),
    .q_full          (q_full),
    .busy            (busy),
    .push            (push),
    .push_cmd        (push_cmd)
  );

  // Hold commands while the back end walks the store for a collect
  prc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: update slots, run the CRC walk, drive results
  prc_back #(
    .MAX_PACKETS  (MAX_PACKETS),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .done          (done),
    .status        (status),
    .payload_bytes (payload_bytes),
    .computed_crc  (computed_crc)
  );

endmodule

@@ design/prc_checker.sv @@
`include "packet_reassembly_crc_check_macros.svh"

module prc_checker import prc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [12:0] payload_bytes,
  input logic [31:0] computed_crc
);

  logic fail_done;
  logic early_done;

  assign fail_done  = done && (status != ST_OK);
  assign early_done = done && ((status == ST_INCOMPLETE) || (status == ST_SHORT));

  // Length is reported only for a good message
  `PRC_ASSERT_NOW(a_len_only_ok, fail_done, payload_bytes == 13'd0, "length on failed collect")

  // No CRC is computed when the check never reaches the walk
  `PRC_ASSERT_NOW(a_crc_zero_early, early_done, computed_crc == 32'd0, "crc on early result")

  // Out of reset the block is free and silent
  `PRC_ASSERT_NOW(a_reset_quiet, $past(rst), !busy && !done, "busy or done right after reset")

endmodule

bind packet_reassembly_crc_check prc_checker u_prc_checker (.*);

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import prc_pkg::*;

  localparam int         SLOTS       = 16;
  localparam int         SLOT_DEPTH  = 512;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         ITEM_GOAL   = 1100;
  localparam int         RESULT_GOAL = 60;
  localparam int         CYCLE_LIMIT = 40000000;

  // Shapes of message that the random part builds
  typedef enum int {
    KIND_GOOD,
    KIND_CORRUPT,
    KIND_MISSING,
    KIND_RESEND,
    KIND_BAD_TOTAL,
    KIND_SHORT,
    KIND_OVERFLOW
  } msg_kind_t;

  typedef struct {
    logic [1:0]  status;
    logic [12:0] payload;
    logic [31:0] crc;
  } verdict_t;

  // Mirror of the slot store: predicts the verdict of every collect and checks
  // the block's answers in order.
  class reassembly_scoreboard;
    logic [7:0] slot_bytes [SLOTS][SLOT_DEPTH];
    logic [9:0] slot_len [SLOTS];
    logic       slot_used [SLOTS];
    logic [4:0] expected_count;
    verdict_t   pending_verdicts [$];
    int         mismatches;
    int         transactions;
    int         collects;
    int         verdicts_checked;
    int         status_seen [4];

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        slot_len[s]  = '0;
        slot_used[s] = 1'b0;
      end
      expected_count = '0;
      mismatches = 0;
      transactions = 0;
      collects = 0;
      verdicts_checked = 0;
      for (int i = 0; i < 4; i++) status_seen[i] = 0;
    endfunction

    // Reflected CRC-32 over a whole byte sequence
    static function logic [31:0] crc32_of(input logic [7:0] bytes_in [$]);
      logic [31:0] c;
      c = CRC_INIT;
      foreach (bytes_in[i]) begin
        c = c ^ {24'd0, bytes_in[i]};
        for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
    endfunction

    function verdict_t predict_collect();
      verdict_t    v;
      logic [7:0]  joined [$];
      logic [31:0] received;
      int          occupied;
      int          n;
      v.status  = ST_OK;
      v.payload = '0;
      v.crc     = '0;
      occupied  = 0;
      // join occupied slots in index order, skipping gaps
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_used[s]) begin
          occupied++;
          for (int k = 0; k < slot_len[s]; k++) joined.push_back(slot_bytes[s][k]);
        end
      end
      if (occupied != expected_count) begin
        v.status = ST_INCOMPLETE;
        return v;
      end
      n = joined.size();
      if (n < 4) begin
        v.status = ST_SHORT;
        return v;
      end
      received = {joined[n-1], joined[n-2], joined[n-3], joined[n-4]};
      repeat (4) void'(joined.pop_back());
      v.crc = crc32_of(joined);
      if (v.crc != received) v.status = ST_MISMATCH;
      else v.payload = 13'(n - 4);
      return v;
    endfunction

    function void note_transaction(logic [1:0] req, logic [3:0] slot, logic [4:0] total,
                                   logic [7:0] data, logic first);
      transactions++;
      case (req)
        REQ_BYTE: begin
          expected_count = total;
          if (first) slot_len[slot] = '0;
          slot_used[slot] = 1'b1;
          // drop bytes past the slot capacity, slot stays occupied
          if (slot_len[slot] < SLOT_DEPTH) begin
            slot_bytes[slot][slot_len[slot]] = data;
            slot_len[slot] = slot_len[slot] + 10'd1;
          end
        end
        REQ_COLLECT: begin
          collects++;
          pending_verdicts.push_back(predict_collect());
        end
        REQ_CLEAR: begin
          // expected count survives a clear
          for (int s = 0; s < SLOTS; s++) begin
            slot_len[s]  = '0;
            slot_used[s] = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task check_result(logic [1:0] status, logic [12:0] payload, logic [31:0] crc);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result with no collect outstanding (status %0d)", status));
        return;
      end
      want = pending_verdicts.pop_front();
      verdicts_checked++;
      status_seen[want.status]++;
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (payload !== want.payload)
        report_mismatch($sformatf("payload_bytes %0d, want %0d", payload, want.payload));
      if (crc !== want.crc)
        report_mismatch($sformatf("computed_crc %08h, want %08h", crc, want.crc));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  req_type = REQ_BYTE;
  logic [3:0]  packet_index = '0;
  logic [4:0]  total_packets = '0;
  logic [7:0]  data_byte = '0;
  logic        first_of_packet = 1'b0;
  logic        busy;
  logic        done;
  logic [1:0]  status;
  logic [12:0] payload_bytes;
  logic [31:0] computed_crc;

  reassembly_scoreboard sb;
  int accepted;     // transactions the block acts on (unused codes excluded)
  int idle_pct;     // chance of a sender gap after each transaction
  int calm_left;    // transactions left in the current stretch with no gaps
  int cycle_count;

  packet_reassembly_crc_check uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .packet_index(packet_index),
    .total_packets(total_packets),
    .data_byte(data_byte),
    .first_of_packet(first_of_packet),
    .done(done),
    .status(status),
    .payload_bytes(payload_bytes),
    .computed_crc(computed_crc)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Run guard: end the run if the stimulus or the results never finish.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result monitor: the receiver never stalls, so take every done cycle as a
  // transaction. Values read here are the ones before the edge.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, payload_bytes, computed_crc);
  end

  // Drive one request and hold it until the block takes it (start && !busy at
  // an edge). Keep start high when the next request follows directly, so start
  // only ever gets one assignment per edge.
  task automatic issue(logic [1:0] req, logic [3:0] slot, logic [4:0] total,
                       logic [7:0] data, logic first);
    start           <= 1'b1;
    req_type        <= req;
    packet_index    <= slot;
    total_packets   <= total;
    data_byte       <= data;
    first_of_packet <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_transaction(req, slot, total, data, first);
    if (req != REQ_UNUSED) accepted++;
    // Insert a sender gap now and then, with calm stretches in between.
    if (calm_left > 0) begin
      calm_left--;
    end else if ($urandom_range(99) < 3) begin
      calm_left = $urandom_range(20, 60);
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Collect, clear or unused code: the other fields carry noise.
  task automatic issue_control(logic [1:0] req);
    issue(req, 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Hold off the sender until every outstanding collect has answered.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // Build one message (body plus its CRC, little-endian), spread it over
  // distinct slots in ascending order, send the packets in random order, then
  // collect. The kind decides how the message is broken.
  task automatic send_message(msg_kind_t kind);
    logic [7:0]  msg [$];
    logic [31:0] fcs;
    logic [15:0] taken;
    logic [4:0]  total_field;
    int          pkt_len [SLOTS];
    int          pkt_slot [SLOTS];
    int          pkt_base [SLOTS];
    int          order [SLOTS];
    int          body_len, n, hi, pick, tmp, k, skip, redo;

    if (kind == KIND_OVERFLOW) body_len = SLOT_DEPTH - 4;
    else if ($urandom_range(7) == 0) body_len = $urandom_range(13, 60);
    else body_len = $urandom_range(0, 12);
    for (int i = 0; i < body_len; i++) msg.push_back(8'($urandom));
    fcs = reassembly_scoreboard::crc32_of(msg);
    for (int i = 0; i < 4; i++) msg.push_back(fcs[8*i +: 8]);
    if (kind == KIND_SHORT) begin
      msg.delete();
      repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
    end
    if (kind == KIND_CORRUPT) begin
      // a single flipped bit always breaks the CRC
      k = $urandom_range(msg.size() - 1);
      msg[k] = msg[k] ^ (8'd1 << $urandom_range(7));
    end

    // Pick the packet count, mostly small, sometimes up to all slots.
    hi = (msg.size() < 6) ? msg.size() : 6;
    if ($urandom_range(5) == 0) hi = (msg.size() < SLOTS) ? msg.size() : SLOTS;
    if (kind == KIND_OVERFLOW) hi = 1;
    n = $urandom_range(1, hi);
    if (kind == KIND_MISSING && n < 2 && msg.size() >= 2) n = 2;

    // Give each packet one byte, then scatter the rest.
    for (int i = 0; i < n; i++) begin
      pkt_len[i] = 1;
      order[i]   = i;
    end
    for (int i = n; i < msg.size(); i++) begin
      pick = $urandom_range(n - 1);
      pkt_len[pick]++;
    end
    pkt_base[0] = 0;
    for (int i = 1; i < n; i++) pkt_base[i] = pkt_base[i-1] + pkt_len[i-1];

    // Distinct slots, assigned in ascending order so the join restores the message.
    taken = '0;
    for (int i = 0; i < n; i++) begin
      do pick = $urandom_range(SLOTS - 1); while (taken[pick]);
      taken[pick] = 1'b1;
    end
    k = 0;
    for (int s = 0; s < SLOTS; s++) begin
      if (taken[s]) begin
        pkt_slot[k] = s;
        k++;
      end
    end
    for (int i = n - 1; i > 0; i--) begin
      pick = $urandom_range(i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end

    total_field = 5'(n);
    if (kind == KIND_BAD_TOTAL) begin
      while (total_field == 5'(n)) total_field = 5'($urandom);
    end
    skip = (kind == KIND_MISSING) ? order[$urandom_range(n - 1)] : -1;
    redo = (kind == KIND_RESEND) ? order[$urandom_range(n - 1)] : -1;

    for (int j = 0; j < n; j++) begin
      k = order[j];
      if (k != skip) begin
        for (int b = 0; b < pkt_len[k]; b++)
          issue(REQ_BYTE, 4'(pkt_slot[k]), total_field, msg[pkt_base[k] + b], b == 0);
        if (k == redo) begin
          // Overwrite with a bad copy, then resend the true packet on top.
          for (int b = 0; b < $urandom_range(1, 5); b++)
            issue(REQ_BYTE, 4'(pkt_slot[k]), total_field, 8'($urandom), b == 0);
          for (int b = 0; b < pkt_len[k]; b++)
            issue(REQ_BYTE, 4'(pkt_slot[k]), total_field, msg[pkt_base[k] + b], b == 0);
        end
      end
    end
    // Push bytes past a full slot: they must vanish.
    if (kind == KIND_OVERFLOW) begin
      repeat (8) issue(REQ_BYTE, 4'(pkt_slot[0]), total_field, 8'($urandom), 1'b0);
    end

    // A collect leaves state alone, so a second one must agree with the first.
    repeat (($urandom_range(3) == 0) ? 2 : 1) issue_control(REQ_COLLECT);
  endtask

  initial begin
    int        phase, last_phase, r;
    bit        overflow_done;
    msg_kind_t kind;

    sb = new();
    accepted = 0;
    idle_pct = 0;
    calm_left = 0;

    // Hold reset, then release it for good.
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part
    issue_control(REQ_COLLECT);                          // empty store: too short
    issue(REQ_BYTE, 4'd15, 5'd31, 8'hFF, 1'b1);          // top slot, top count
    issue_control(REQ_COLLECT);                          // count differs: incomplete
    issue(REQ_UNUSED, 4'hF, 5'h1F, 8'hFF, 1'b1);         // unused code: ignored
    issue(REQ_CLEAR, 4'h0, 5'h00, 8'h00, 1'b0);          // clear keeps the count
    issue_control(REQ_COLLECT);                          // still incomplete
    issue(REQ_BYTE, 4'd0, 5'd1, 8'h00, 1'b1);
    issue_control(REQ_COLLECT);                          // one byte: too short
    repeat (3) issue(REQ_BYTE, 4'd0, 5'd1, 8'h00, 1'b0);
    issue_control(REQ_COLLECT);                          // empty body, zero CRC: ok
    issue(REQ_BYTE, 4'd0, 5'd1, 8'hA5, 1'b0);
    issue_control(REQ_COLLECT);                          // CRC mismatch
    issue(REQ_BYTE, 4'd0, 5'd2, 8'h5A, 1'b1);            // resend shrinks slot 0
    issue(REQ_BYTE, 4'd9, 5'd2, 8'h00, 1'b1);            // gap between slots
    repeat (3) issue(REQ_BYTE, 4'd9, 5'd2, 8'hFF, 1'b0);
    issue_control(REQ_COLLECT);
    issue_control(REQ_COLLECT);
    issue(REQ_UNUSED, 4'h0, 5'h00, 8'h00, 1'b0);
    drain_results();

    // Random part, in four idling phases; drain the results at each change.
    last_phase = -1;
    overflow_done = 0;
    while (accepted < ITEM_GOAL || sb.collects < RESULT_GOAL) begin
      phase = accepted * 4 / ITEM_GOAL;
      if (phase > 3) phase = 3;
      if (phase != last_phase) begin
        drain_results();
        case (phase)
          0: idle_pct = 0;
          1: idle_pct = 74;
          2: idle_pct = 0;    // receiver stalls cannot happen here
          default: idle_pct = 31;
        endcase
        last_phase = phase;
      end
      if (!overflow_done && accepted > ITEM_GOAL / 3) begin
        issue_control(REQ_CLEAR);
        send_message(KIND_OVERFLOW);
        overflow_done = 1;
      end else begin
        r = $urandom_range(99);
        if (r < 8) begin
          // noise: any code, any field values
          repeat ($urandom_range(4, 12))
            issue(2'($urandom), 4'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
        end else begin
          if ($urandom_range(99) < 85) issue_control(REQ_CLEAR);
          r = $urandom_range(99);
          if (r < 50) kind = KIND_GOOD;
          else if (r < 62) kind = KIND_CORRUPT;
          else if (r < 72) kind = KIND_MISSING;
          else if (r < 82) kind = KIND_RESEND;
          else if (r < 91) kind = KIND_BAD_TOTAL;
          else kind = KIND_SHORT;
          send_message(kind);
        end
      end
    end

    // Let the last collects answer, then watch for stray results.
    drain_results();
    repeat (100) @(posedge clk);

    $display("summary: %0d transactions, %0d collect results checked", sb.transactions,
             sb.verdicts_checked);
    $display("summary: ok %0d, incomplete %0d, crc mismatch %0d, too short %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_INCOMPLETE],
             sb.status_seen[ST_MISMATCH], sb.status_seen[ST_SHORT]);
    if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/prc_pkg.sv
design/prc_front.sv
design/prc_queue.sv
design/prc_back.sv
design/packet_reassembly_crc_check.sv
design/prc_checker.sv
bench/tb.sv
